/* rtl/rcorc_pkg.sv */
// Shared types, constants and helper functions of the row and column occupancy checker.
package rcorc_pkg;

	localparam int SIDE_DEF = 1024;
	localparam int POS_W    = 10;
	localparam int CNT_W    = 11;
	localparam int WORD_W   = 64;
	localparam int BIT_W    = $clog2(WORD_W);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BIT_W-1:0]  bit_idx_t;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		pos_t    row_lo;
		pos_t    col_lo;
		pos_t    row_hi;
		pos_t    col_hi;
	} item_t;

	typedef struct packed {
		logic covered;
		logic fault;
	} result_t;

	// Operations that one axis unit carries out.
	typedef enum logic [1:0] {
		AX_INC  = 2'd0,
		AX_DEC  = 2'd1,
		AX_SCAN = 2'd2
	} axop_t;

	typedef struct packed {
		logic  start;
		axop_t op;
		pos_t  lo;
		pos_t  hi;
	} axis_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic flag;
	} axis_stat_t;

	// True when a position lies inside a grid of the given side.
	function automatic logic in_grid(pos_t p, int side);
		logic [31:0] p32;
		p32 = {{(32-POS_W){1'b0}}, p};
		return p32 < 32'(side);
	endfunction

	// Bits lo_b up to hi_b of one presence word set, the rest clear.
	function automatic word_t word_mask(bit_idx_t lo_b, bit_idx_t hi_b);
		word_t    ones;
		bit_idx_t top_gap;
		ones    = {WORD_W{1'b1}};
		top_gap = bit_idx_t'(WORD_W - 1) - hi_b;
		return (ones << lo_b) & (ones >> top_gap);
	endfunction

endpackage

/* rtl/row_col_occupancy_range_check.sv */
// Top level of the row and column occupancy checker: handshakes, item sequencer and result register.
// Add and remove items: each axis unit reads the count and presence word, then updates and
// writes them back. Query items: each axis unit scans the 64-bit presence words that its range
// spans, at most 16 for a side of 1024; both axes are scanned side by side.
// One item is in flight at a time; the next is taken the cycle after its result is registered.
// After reset a clearing pass zeroes the count and presence memories while
// item_ready stays low.
module row_col_occupancy_range_check #(
	parameter int SIDE = rcorc_pkg::SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rcorc_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output rcorc_pkg::result_t result
);
	import rcorc_pkg::*;

	// The sequencer is either waiting for an item or waiting for both axis units to finish.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t     state_q;
	action_t    act_q;
	axis_cmd_t  row_cmd_q, col_cmd_q;
	axis_stat_t row_st, col_st;
	logic       row_done_q, col_done_q;
	logic       row_flag_q, col_flag_q;
	logic       result_valid_q;
	result_t    result_q;
	logic       accept;
	logic       out_free;
	logic       finish;
	logic       any_flag;

	// Each axis unit owns its own count memory and presence words; the row unit sees the row
	// fields of the item and the column unit the column fields.
	rcorc_axis #(.SIDE(SIDE)) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (row_cmd_q),
		.stat   (row_st)
	);

	rcorc_axis #(.SIDE(SIDE)) u_col (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (col_cmd_q),
		.stat   (col_st)
	);

	// An item is taken only when the sequencer is free and both units have left their
	// clearing pass and are idle.
	assign item_ready = (state_q == ST_IDLE) && row_st.idle && col_st.idle;
	assign accept     = item_valid && item_ready;

	// The result register may be reloaded when it is empty or is being emptied this cycle.
	assign out_free = !result_valid_q || result_ready;
	assign finish   = (state_q == ST_RUN) && row_done_q && col_done_q && out_free;
	assign any_flag = row_flag_q || col_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			act_q          <= ACT_NONE;
			row_cmd_q      <= '0;
			col_cmd_q      <= '0;
			row_done_q     <= 1'b0;
			col_done_q     <= 1'b0;
			row_flag_q     <= 1'b0;
			col_flag_q     <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// Start requests are single-cycle pulses.
			row_cmd_q.start <= 1'b0;
			col_cmd_q.start <= 1'b0;

			if (row_st.done) begin
				row_done_q <= 1'b1;
				row_flag_q <= row_st.flag;
			end
			if (col_st.done) begin
				col_done_q <= 1'b1;
				col_flag_q <= col_st.flag;
			end

			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q        <= item.action;
						row_cmd_q.lo <= item.row_lo;
						row_cmd_q.hi <= item.row_hi;
						col_cmd_q.lo <= item.col_lo;
						col_cmd_q.hi <= item.col_hi;
						row_done_q   <= 1'b0;
						col_done_q   <= 1'b0;
						row_flag_q   <= 1'b0;
						col_flag_q   <= 1'b0;
						state_q      <= ST_RUN;
						unique case (item.action)
							ACT_ADD: begin
								row_cmd_q.start <= 1'b1;
								row_cmd_q.op    <= AX_INC;
								col_cmd_q.start <= 1'b1;
								col_cmd_q.op    <= AX_INC;
							end
							ACT_REMOVE: begin
								row_cmd_q.start <= 1'b1;
								row_cmd_q.op    <= AX_DEC;
								col_cmd_q.start <= 1'b1;
								col_cmd_q.op    <= AX_DEC;
							end
							ACT_QUERY: begin
								row_cmd_q.start <= 1'b1;
								row_cmd_q.op    <= AX_SCAN;
								col_cmd_q.start <= 1'b1;
								col_cmd_q.op    <= AX_SCAN;
							end
							default: begin
								// The unused action starts neither axis unit; its result carries both flags clear.
								row_done_q <= 1'b1;
								col_done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (finish) begin
						// A query reports coverage, an update reports a fault; either axis
						// is enough to raise the flag.
						result_q.covered <= (act_q == ACT_QUERY) && any_flag;
						result_q.fault   <= (act_q == ACT_ADD || act_q == ACT_REMOVE) && any_flag;
						result_valid_q   <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Once an item is taken, no second item may be taken on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("item taken while the previous one is still in progress");

	// Coverage and fault come from different kinds of item and are never raised together.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.covered && result.fault))
		else $error("result carries both covered and fault");

	// The axis units only report completion for an item that the sequencer is running.
	a_row_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		row_st.done |-> state_q == ST_RUN)
		else $error("row unit finished with no item in progress");

	a_col_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		col_st.done |-> state_q == ST_RUN)
		else $error("column unit finished with no item in progress");
`endif

endmodule

/* rtl/rcorc_axis.sv */
// One axis: reference count memory, packed presence words and the shared update and scan unit.
module rcorc_axis #(
	parameter int SIDE = rcorc_pkg::SIDE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rcorc_pkg::axis_cmd_t   cmd,
	output rcorc_pkg::axis_stat_t  stat
);
	import rcorc_pkg::*;

	localparam int IDX_W  = $clog2(SIDE);
	localparam int NWORDS = (SIDE + WORD_W - 1) / WORD_W;
	localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UPD,
		S_SCAN,
		S_SCAN_END
	} state_t;

	state_t            state_q;
	axop_t             op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  clr_q;
	logic [WIDX_W-1:0] w_q;
	logic [WIDX_W-1:0] lo_w_q;
	logic [WIDX_W-1:0] last_w_q;
	logic [WIDX_W-1:0] chk_w_s1;
	bit_idx_t          bit_q;
	bit_idx_t          lo_bit_q;
	bit_idx_t          hi_bit_q;
	logic              ok_q;
	logic              chk_s1;
	logic              done_q;
	logic              flag_q;

	cnt_t  cnt_mem [SIDE];
	word_t pres_mem [NWORDS];
	cnt_t  cnt_rd_q;
	word_t pres_rd_q;

	logic              cnt_ren, cnt_we, pres_ren, pres_we;
	logic [IDX_W-1:0]  cnt_raddr, cnt_waddr;
	logic [WIDX_W-1:0] pres_raddr, pres_waddr;
	cnt_t              cnt_wdata;
	word_t             pres_wdata;

	logic [31:0]       lo32, hi32, clr32;
	logic [IDX_W-1:0]  cmd_idx;
	logic [WIDX_W-1:0] cmd_lo_w, cmd_hi_w;
	logic              upd_fault;
	cnt_t              upd_cnt;
	bit_idx_t          chk_lo, chk_hi;
	word_t             chk_mask;
	logic              chk_ok;

	assign lo32     = {{(32-POS_W){1'b0}}, cmd.lo};
	assign hi32     = {{(32-POS_W){1'b0}}, cmd.hi};
	assign clr32    = {{(32-IDX_W){1'b0}}, clr_q};
	assign cmd_idx  = IDX_W'(lo32);
	assign cmd_lo_w = WIDX_W'(lo32 >> BIT_W);
	assign cmd_hi_w = WIDX_W'(hi32 >> BIT_W);

	assign upd_fault = (op_q == AX_INC) ? (cnt_rd_q == CNT_MAX) : (cnt_rd_q == '0);
	assign upd_cnt   = (op_q == AX_INC) ? cnt_rd_q + cnt_t'(1) : cnt_rd_q - cnt_t'(1);

	// Only the first and last words of a span are trimmed at their edges.
	assign chk_lo   = (chk_w_s1 == lo_w_q) ? lo_bit_q : '0;
	assign chk_hi   = (chk_w_s1 == last_w_q) ? hi_bit_q : '1;
	assign chk_mask = word_mask(chk_lo, chk_hi);
	assign chk_ok   = (pres_rd_q & chk_mask) == chk_mask;

	always_comb begin
		cnt_ren    = 1'b0;
		pres_ren   = 1'b0;
		cnt_raddr  = cmd_idx;
		pres_raddr = cmd_lo_w;
		cnt_we     = 1'b0;
		pres_we    = 1'b0;
		cnt_waddr  = idx_q;
		pres_waddr = w_q;
		cnt_wdata  = upd_cnt;
		pres_wdata = pres_rd_q;
		pres_wdata[bit_q] = (upd_cnt != '0);
		unique case (state_q)
			S_CLEAR: begin
				cnt_we     = 1'b1;
				cnt_waddr  = clr_q;
				cnt_wdata  = '0;
				pres_we    = clr32 < 32'(NWORDS);
				pres_waddr = WIDX_W'(clr_q);
				pres_wdata = '0;
			end
			S_IDLE: begin
				if (cmd.start && (cmd.op == AX_INC || cmd.op == AX_DEC) &&
						in_grid(cmd.lo, SIDE)) begin
					cnt_ren  = 1'b1;
					pres_ren = 1'b1;
				end
			end
			S_UPD: begin
				cnt_we  = !upd_fault;
				pres_we = !upd_fault;
			end
			S_SCAN: begin
				pres_ren   = 1'b1;
				pres_raddr = w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_ren) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_waddr] <= pres_wdata;
		end
		if (pres_ren) begin
			pres_rd_q <= pres_mem[pres_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			op_q     <= AX_INC;
			idx_q    <= '0;
			w_q      <= '0;
			bit_q    <= '0;
			lo_w_q   <= '0;
			last_w_q <= '0;
			lo_bit_q <= '0;
			hi_bit_q <= '0;
			ok_q     <= 1'b0;
			chk_s1   <= 1'b0;
			chk_w_s1 <= '0;
			done_q   <= 1'b0;
			flag_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(SIDE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.start) begin
						unique case (cmd.op)
							AX_INC, AX_DEC: begin
								if (in_grid(cmd.lo, SIDE)) begin
									op_q    <= cmd.op;
									idx_q   <= cmd_idx;
									w_q     <= cmd_lo_w;
									bit_q   <= cmd.lo[BIT_W-1:0];
									state_q <= S_UPD;
								end else begin
									done_q <= 1'b1;
									flag_q <= 1'b0;
								end
							end
							AX_SCAN: begin
								if (cmd.lo <= cmd.hi && in_grid(cmd.hi, SIDE)) begin
									w_q      <= cmd_lo_w;
									lo_w_q   <= cmd_lo_w;
									last_w_q <= cmd_hi_w;
									lo_bit_q <= cmd.lo[BIT_W-1:0];
									hi_bit_q <= cmd.hi[BIT_W-1:0];
									ok_q     <= 1'b1;
									state_q  <= S_SCAN;
								end else begin
									done_q <= 1'b1;
									flag_q <= 1'b0;
								end
							end
							default: begin
								done_q <= 1'b1;
								flag_q <= 1'b0;
							end
						endcase
					end
				end
				S_UPD: begin
					done_q  <= 1'b1;
					flag_q  <= upd_fault;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					chk_s1   <= 1'b1;
					chk_w_s1 <= w_q;
					if (chk_s1) begin
						ok_q <= ok_q & chk_ok;
					end
					if (w_q == last_w_q) begin
						state_q <= S_SCAN_END;
					end else begin
						w_q <= w_q + WIDX_W'(1);
					end
				end
				S_SCAN_END: begin
					chk_s1  <= 1'b0;
					done_q  <= 1'b1;
					flag_q  <= ok_q & chk_ok;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = done_q;
	assign stat.flag = flag_q;

endmodule
